[design/smx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

	// Data word width and default stack size
	localparam int DATA_W          = 32;
	localparam int STACK_DEPTH_DEF = 256;

	// Instruction codes
	typedef enum logic [3:0] {
		OP_HALT = 4'd0,
		OP_NOP  = 4'd1,
		OP_PUSH = 4'd2,
		OP_POP  = 4'd3,
		OP_ADD  = 4'd4,
		OP_SUB  = 4'd5,
		OP_MUL  = 4'd6,
		OP_DIV  = 4'd7,
		OP_MOD  = 4'd8,
		OP_AND  = 4'd9,
		OP_OR   = 4'd10,
		OP_NOT  = 4'd11
	} op_t;

	// Completion status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_HALTED    = 3'd4
	} status_t;

	// Divider control from the sequencer
	typedef struct packed {
		logic start;
		logic want_rem;
	} div_req_t;

endpackage

`default_nettype wire

[design/smx_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

// Signed truncating divide / remainder, restoring, one quotient bit per cycle.
// The result registers together with a one-cycle done pulse after the last step.
module smx_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire smx_pkg::div_req_t           req,
	input  wire logic [smx_pkg::DATA_W-1:0]  dividend,
	input  wire logic [smx_pkg::DATA_W-1:0]  divisor,
	output logic                             done,
	output logic [smx_pkg::DATA_W-1:0]       result
);

	localparam int W   = smx_pkg::DATA_W;
	localparam int CW  = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          want_rem_q;
	logic          neg_num_q;
	logic          neg_den_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  result_q;

	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic [W-1:0]  mag_num;
	logic [W-1:0]  mag_den;
	logic [W-1:0]  fix_rem;
	logic [W-1:0]  fix_quo;

	// Operand magnitudes and one restoring step
	always_comb begin
		mag_num = dividend[W-1] ? (~dividend + 1'b1) : dividend;
		mag_den = divisor[W-1] ? (~divisor + 1'b1) : divisor;
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, den_q};
		fix_rem = neg_num_q ? (~rem_q + 1'b1) : rem_q;
		fix_quo = (neg_num_q ^ neg_den_q) ? (~quo_q + 1'b1) : quo_q;
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			want_rem_q <= req.want_rem;
			neg_num_q  <= dividend[W-1];
			neg_den_q  <= divisor[W-1];
			rem_q      <= '0;
			quo_q      <= mag_num;
			den_q      <= mag_den;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end else begin
				result_q <= want_rem_q ? fix_rem : fix_quo;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("done without iteration");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0) else $error("step count left over");

endmodule

`default_nettype wire

[design/stack_machine_executor_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Path from the accepting edge to the result in the output register: halt, nop, push,
// overflow, underflow and any request after halt go straight to S_FIN; pop and not pass
// S_RD_A and S_RD_B; add, sub, mul, and, or and a zero divisor also pass S_EXEC; div and mod
// then wait in S_DIV on the one-bit-per-cycle divider. One request at a time: the next is
// taken the cycle after the result registers, and S_FIN holds while the output stalls.
// Reset empties the stack and sets the machine running; stack contents are not cleared.
module stack_machine_executor_core #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [3:0]                  op,
	input  wire logic signed [31:0]          immediate,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [2:0]                       status,
	output logic                             pop_valid,
	output logic signed [31:0]               pop_value,
	output logic                             halted
);

	localparam int W      = smx_pkg::DATA_W;
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD_A = 6'b000010,
		S_RD_B = 6'b000100,
		S_EXEC = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                state_q;
	smx_pkg::op_t          op_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  running_q;
	logic [W-1:0]          a_q;
	logic [W-1:0]          rd_data_q;
	smx_pkg::status_t      res_status_q;
	logic                  res_pop_valid_q;
	logic [W-1:0]          res_pop_value_q;

	logic                  out_valid_q;
	smx_pkg::status_t      status_q;
	logic                  pop_valid_q;
	logic [W-1:0]          pop_value_q;
	logic                  halted_q;

	logic [W-1:0]          mem [STACK_DEPTH];

	logic                  accept;
	logic [CNT_W-1:0]      idx1;
	logic [CNT_W-1:0]      idx2;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [W-1:0]          wr_data;
	logic [W-1:0]          alu_res;
	logic                  is_divmod;
	logic                  has_room;
	smx_pkg::div_req_t     div_req;
	logic                  div_done;
	logic [W-1:0]          div_result;

	// Handshake and stack indexes
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign idx1      = cnt_q - CNT_W'(1);
	assign idx2      = cnt_q - CNT_W'(2);
	assign has_room  = (cnt_q < CNT_W'(STACK_DEPTH));
	assign is_divmod = (op_q == smx_pkg::OP_DIV) || (op_q == smx_pkg::OP_MOD);

	// Two-operand ALU: a is the top, b (read data) is the one below
	always_comb begin
		case (op_q)
			smx_pkg::OP_ADD: alu_res = rd_data_q + a_q;
			smx_pkg::OP_SUB: alu_res = rd_data_q - a_q;
			smx_pkg::OP_MUL: alu_res = rd_data_q * a_q;
			smx_pkg::OP_AND: alu_res = rd_data_q & a_q;
			default:         alu_res = rd_data_q | a_q;
		endcase
	end

	// Stack RAM port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx1[ADDR_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx2[ADDR_W-1:0];
		wr_data = alu_res;
		case (state_q)
			S_IDLE: begin
				if (accept && running_q && (op == smx_pkg::OP_PUSH) && has_room) begin
					wr_en   = 1'b1;
					wr_addr = cnt_q[ADDR_W-1:0];
					wr_data = immediate;
				end
			end
			S_RD_A: begin
				rd_en = 1'b1;
			end
			S_RD_B: begin
				rd_en   = 1'b1;
				rd_addr = idx2[ADDR_W-1:0];
				if (op_q == smx_pkg::OP_NOT) begin
					wr_en   = 1'b1;
					wr_addr = idx1[ADDR_W-1:0];
					wr_data = {{(W-1){1'b0}}, (rd_data_q == '0)};
				end
			end
			S_EXEC: begin
				wr_en = !is_divmod;
			end
			S_DIV: begin
				wr_en   = div_done;
				wr_data = div_result;
			end
			default: begin
			end
		endcase
	end

	// Operand stack storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Shared divider
	assign div_req.start    = (state_q == S_EXEC) && is_divmod && (a_q != '0);
	assign div_req.want_rem = (op_q == smx_pkg::OP_MOD);

	smx_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (rd_data_q),
		.divisor  (a_q),
		.done     (div_done),
		.result   (div_result)
	);

	// Sequencer and machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			running_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						if (running_q) begin
							case (op)
								smx_pkg::OP_HALT: running_q <= 1'b0;
								smx_pkg::OP_PUSH: begin
									if (has_room) begin
										cnt_q <= cnt_q + CNT_W'(1);
									end else begin
										running_q <= 1'b0;
									end
								end
								smx_pkg::OP_POP, smx_pkg::OP_NOT: begin
									if (cnt_q != '0) begin
										state_q <= S_RD_A;
									end else begin
										running_q <= 1'b0;
									end
								end
								smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL,
								smx_pkg::OP_DIV, smx_pkg::OP_MOD, smx_pkg::OP_AND,
								smx_pkg::OP_OR: begin
									if (cnt_q >= CNT_W'(2)) begin
										state_q <= S_RD_A;
									end else begin
										running_q <= 1'b0;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: begin
					if (op_q == smx_pkg::OP_POP) begin
						cnt_q   <= idx1;
						state_q <= S_FIN;
					end else if (op_q == smx_pkg::OP_NOT) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (!is_divmod) begin
						cnt_q   <= idx1;
						state_q <= S_FIN;
					end else if (a_q == '0) begin
						running_q <= 1'b0;
						state_q   <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						cnt_q   <= idx1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result fields gathered while the request runs
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q            <= smx_pkg::op_t'(op);
					res_status_q    <= smx_pkg::ST_OK;
					res_pop_valid_q <= 1'b0;
					res_pop_value_q <= '0;
					if (!running_q) begin
						res_status_q <= smx_pkg::ST_HALTED;
					end else begin
						case (op)
							smx_pkg::OP_PUSH: begin
								if (!has_room) begin
									res_status_q <= smx_pkg::ST_OVERFLOW;
								end
							end
							smx_pkg::OP_POP, smx_pkg::OP_NOT: begin
								if (cnt_q == '0) begin
									res_status_q <= smx_pkg::ST_UNDERFLOW;
								end
							end
							smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL,
							smx_pkg::OP_DIV, smx_pkg::OP_MOD, smx_pkg::OP_AND,
							smx_pkg::OP_OR: begin
								if (cnt_q < CNT_W'(2)) begin
									res_status_q <= smx_pkg::ST_UNDERFLOW;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			S_RD_B: begin
				a_q <= rd_data_q;
				if (op_q == smx_pkg::OP_POP) begin
					res_pop_valid_q <= 1'b1;
					res_pop_value_q <= rd_data_q;
				end
			end
			S_EXEC: begin
				if (is_divmod && (a_q == '0)) begin
					res_status_q <= smx_pkg::ST_DIVZERO;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					status_q    <= res_status_q;
					pop_valid_q <= res_pop_valid_q;
					pop_value_q <= res_pop_value_q;
					halted_q    <= !running_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pop_valid = pop_valid_q;
	assign pop_value = pop_value_q;
	assign halted    = halted_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH)) else $error("stack count beyond depth");
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |=> !running_q) else $error("machine restarted after halt");
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pop_valid_q |-> status_q == smx_pkg::ST_OK && !halted_q)
		else $error("pop result with error status");
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != smx_pkg::ST_OK |-> halted_q)
		else $error("error status without halt");

endmodule

`default_nettype wire
